// File: src/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg - shared types and constants of the double-ended queue
// Request codes, status codes, cell operations and default sizes.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int ITEM_WIDTH_DEFAULT = 32;
  localparam int ACTION_WIDTH       = 3;
  localparam int STATUS_WIDTH       = 2;

  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_REAR  = 3'd5
  } action_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation broadcast to every cell of the row.
  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_SHIFT_IN   = 3'd1,  // push front: every word moves one cell toward the rear
    OP_SHIFT_OUT  = 3'd2,  // pop front: every word moves one cell toward the front
    OP_FILL_REAR  = 3'd3,  // push rear: first empty cell takes the word
    OP_DROP_REAR  = 3'd4   // pop rear: last occupied cell lets go
  } cell_op_t;

endpackage

// File: src/deq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_if - request and response channels of the double-ended queue
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface deq_req_if
  import deq_pkg::*;
#(
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic [ACTION_WIDTH-1:0]       action;
  logic signed [ITEM_WIDTH-1:0]  push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface deq_rsp_if
  import deq_pkg::*;
#(
  parameter int ITEM_WIDTH  = ITEM_WIDTH_DEFAULT,
  parameter int COUNT_WIDTH = $clog2(DEPTH_DEFAULT + 1)
);
  logic                          valid;
  logic                          ready;
  logic signed [ITEM_WIDTH-1:0]  item_out;
  logic [STATUS_WIDTH-1:0]       status;
  logic [COUNT_WIDTH-1:0]        item_count;
  logic                          is_empty;

  modport source (output valid, output item_out, output status, output item_count,
                  output is_empty, input ready);
  modport sink   (input valid, input item_out, input status, input item_count,
                  input is_empty, output ready);
endinterface

// File: src/deq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_cell - one storage cell of the queue row
// Holds one word and its occupied flag; trades with its neighbors per op.
// ----------------------------------------------------------------------------
module deq_cell
  import deq_pkg::*;
#(
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT
)(
  input  logic                  clk,
  input  logic                  rst,
  input  cell_op_t              op,
  input  logic [ITEM_WIDTH-1:0] push_value,
  input  logic                  left_valid,
  input  logic [ITEM_WIDTH-1:0] left_data,
  input  logic                  right_valid,
  input  logic [ITEM_WIDTH-1:0] right_data,
  output logic                  valid,
  output logic [ITEM_WIDTH-1:0] data,
  output logic [ITEM_WIDTH-1:0] rear_tap
);

  // Rear cell of the queue: occupied, with an empty neighbor behind it.
  assign rear_tap = (valid && !right_valid) ? data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (op)
        OP_SHIFT_IN: begin
          valid <= left_valid;
        end
        OP_SHIFT_OUT: begin
          valid <= right_valid;
        end
        OP_FILL_REAR: begin
          valid <= valid | left_valid;
        end
        OP_DROP_REAR: begin
          valid <= valid & right_valid;
        end
        default: begin
          valid <= valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_SHIFT_IN: begin
        data <= left_data;
      end
      OP_SHIFT_OUT: begin
        data <= right_data;
      end
      OP_FILL_REAR: begin
        if (!valid && left_valid) begin
          data <= push_value;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

// File: src/deq_rear_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_rear_tree - registered OR tree that collects the rear word
// At most one cell drives a nonzero tap; a register follows every level.
// ----------------------------------------------------------------------------
module deq_rear_tree
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT
)(
  input  logic                  clk,
  input  logic [ITEM_WIDTH-1:0] tap [DEPTH],
  output logic [ITEM_WIDTH-1:0] rear_data
);

  localparam int LEVELS = $clog2(DEPTH);
  localparam int LEAVES = 1 << LEVELS;

  logic [ITEM_WIDTH-1:0] leaf   [LEAVES];
  logic [ITEM_WIDTH-1:0] node_q [1:LEAVES-1];

  // Pad the leaf row up to a power of two with zeros.
  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < DEPTH) begin : g_real
      assign leaf[j] = tap[j];
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  // Heap order: node k combines children 2k and 2k+1.
  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    if (2 * k >= LEAVES) begin : g_bottom
      always_ff @(posedge clk) begin
        node_q[k] <= leaf[2*k-LEAVES] | leaf[2*k+1-LEAVES];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node_q[k] <= node_q[2*k] | node_q[2*k+1];
      end
    end
  end

  assign rear_data = node_q[1];

endmodule

// File: src/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue - double-ended queue built as a row of shifting cells
// Push, pop and peek at either end of a queue of signed words.
// ----------------------------------------------------------------------------
//
//   channel | dir | word carried
//   --------+-----+---------------------------------------------------------
//   req     | in  | action (push/pop/peek, front/rear), push_value
//   rsp     | out | item_out, status, item_count, is_empty
//
// The rear word comes from a registered OR tree of log2(DEPTH) levels,
// which must settle after every change of the cell row; a settle wait
// follows every taken request before the next request is taken.
// Reset clears the occupied flags and the count and starts that same settle
// wait; stored words are not cleared. The response sits in an output
// register: after the settle wait, a new request can be taken in the cycle
// the previous response leaves; a stalled response only blocks new requests.
// ----------------------------------------------------------------------------
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT
)(
  input  logic        clk,
  input  logic        rst,
  deq_req_if.sink     req,
  deq_rsp_if.source   rsp
);

  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
  localparam int LEVELS      = $clog2(DEPTH);
  localparam int WAIT_WIDTH  = $clog2(LEVELS + 1);

  // Cell row: index 0 is the front of the queue.
  logic                  cell_valid [DEPTH];
  logic [ITEM_WIDTH-1:0] cell_data  [DEPTH];
  logic [ITEM_WIDTH-1:0] cell_tap   [DEPTH];
  logic [ITEM_WIDTH-1:0] rear_data;

  cell_op_t              op;
  logic [ITEM_WIDTH-1:0] push_word;

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [WAIT_WIDTH-1:0]  settle;
  logic                   out_valid;
  logic [ITEM_WIDTH-1:0]  item_q;
  logic [ITEM_WIDTH-1:0]  item_next;
  status_t                status_q;
  status_t                status_next;
  cell_op_t               op_next;

  logic accept;
  logic is_full;
  logic is_none;

  assign push_word = req.push_value;
  assign is_full   = (count == COUNT_WIDTH'(DEPTH));
  assign is_none   = (count == '0);

  // Take a request only with a settled rear tree and room in the output register.
  assign req.ready = (settle == '0) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // Decode the request against the current occupancy.
  always_comb begin
    item_next   = '0;
    status_next = ST_OK;
    op_next     = OP_HOLD;
    count_next  = count;
    unique case (action_t'(req.action))
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          op_next    = (action_t'(req.action) == ACT_PUSH_FRONT) ? OP_SHIFT_IN : OP_FILL_REAR;
          count_next = count + COUNT_WIDTH'(1);
        end
      end
      ACT_POP_FRONT, ACT_PEEK_FRONT: begin
        if (is_none) begin
          status_next = ST_EMPTY;
        end else begin
          item_next = cell_data[0];
          if (action_t'(req.action) == ACT_POP_FRONT) begin
            op_next    = OP_SHIFT_OUT;
            count_next = count - COUNT_WIDTH'(1);
          end
        end
      end
      ACT_POP_REAR, ACT_PEEK_REAR: begin
        if (is_none) begin
          status_next = ST_EMPTY;
        end else begin
          item_next = rear_data;
          if (action_t'(req.action) == ACT_POP_REAR) begin
            op_next    = OP_DROP_REAR;
            count_next = count - COUNT_WIDTH'(1);
          end
        end
      end
      default: begin
        // Unused codes: no change, plain OK response.
      end
    endcase
  end

  // Broadcast the cell operation only in the cycle the request is taken.
  assign op = accept ? op_next : OP_HOLD;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
      settle    <= WAIT_WIDTH'(LEVELS);
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
        count     <= count_next;
        settle    <= WAIT_WIDTH'(LEVELS);
      end else begin
        if (rsp.ready) begin
          out_valid <= 1'b0;
        end
        if (settle != '0) begin
          settle <= settle - WAIT_WIDTH'(1);
        end
      end
    end
  end

  // Response payload: hold until the next request is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q   <= item_next;
      status_q <= status_next;
    end
  end

  // Outside reset, count only changes on a taken request, which also reloads the response.
  assign rsp.valid      = out_valid;
  assign rsp.item_out   = item_q;
  assign rsp.status     = status_q;
  assign rsp.item_count = count;
  assign rsp.is_empty   = is_none;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  lv;
    logic [ITEM_WIDTH-1:0] ld;
    logic                  rv;
    logic [ITEM_WIDTH-1:0] rd;

    // Front cell sees an always-occupied neighbor carrying the pushed word.
    if (i == 0) begin : g_front
      assign lv = 1'b1;
      assign ld = push_word;
    end else begin : g_mid_l
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end

    // Last cell sees an empty neighbor behind it.
    if (i == DEPTH - 1) begin : g_back
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_r
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end

    deq_cell #(
      .ITEM_WIDTH (ITEM_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .push_value  (push_word),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .valid       (cell_valid[i]),
      .data        (cell_data[i]),
      .rear_tap    (cell_tap[i])
    );
  end

  deq_rear_tree #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_rear_tree (
    .clk       (clk),
    .tap       (cell_tap),
    .rear_data (rear_data)
  );

endmodule

// File: src/deq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker - port-level checks of the double-ended queue
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT
)(
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [ITEM_WIDTH-1:0]          rsp_item_out,
  input logic [STATUS_WIDTH-1:0]        rsp_status,
  input logic [$clog2(DEPTH+1)-1:0]     rsp_item_count,
  input logic                           rsp_is_empty
);

  localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

  // A taken request shows its response in the next cycle.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("no response after a taken request");

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item_out) && $stable(rsp_status))
    else $error("stalled response changed");

  // Empty flag agrees with the count.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_is_empty == (rsp_item_count == '0))
    else $error("empty flag disagrees with count");

  // Empty status only with no items and a zero word.
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EMPTY |-> rsp_item_count == '0 && rsp_item_out == '0)
    else $error("empty status with items or data");

  // Full status only at full occupancy.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |->
      rsp_item_count == COUNT_WIDTH'(DEPTH) && rsp_item_out == '0)
    else $error("full status below capacity");

endmodule

bind double_ended_queue deq_checker #(
  .DEPTH      (DEPTH),
  .ITEM_WIDTH (ITEM_WIDTH)
) u_deq_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_item_out   (rsp.item_out),
  .rsp_status     (rsp.status),
  .rsp_item_count (rsp.item_count),
  .rsp_is_empty   (rsp.is_empty)
);
